@@ hdl/can_frame_to_ascii_line_encoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the CAN frame ASCII line encoder
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_TO_ASCII_LINE_ENCODER_CORE_MACROS_SVH
`define CAN_FRAME_TO_ASCII_LINE_ENCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define C2A_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("c2a assertion failed");
// next-cycle implication
`define C2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("c2a assertion failed");
`else
`define C2A_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define C2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/c2a_pkg.sv @@
// ----------------------------------------------------------------------------
// c2a_pkg
// Shared types, constants and the hex digit helper.
// ----------------------------------------------------------------------------
package c2a_pkg;

	localparam int MAX_DATA_BYTES_DEF = 8;
	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_LINK_OPEN   = 2'd0;
	localparam logic [1:0] REG_STAMP_EN    = 2'd1;
	localparam logic [1:0] REG_LINE_FEED   = 2'd2;

	localparam logic [15:0] STAMP_MODULUS = 16'd60000;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_EXT_D = 8'h54; // T
	localparam logic [7:0] CHAR_EXT_R = 8'h52; // R
	localparam logic [7:0] CHAR_STD_D = 8'h74; // t
	localparam logic [7:0] CHAR_STD_R = 8'h72; // r
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h41;

	typedef struct packed {
		logic link_open;
		logic stamp_enable;
		logic line_feed_enable;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic shift;
	} shift_ctl_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] res;
		if (nib < 4'd10) begin
			res = CHAR_ZERO + {4'd0, nib};
		end else begin
			res = CHAR_A + {4'd0, nib} - 8'd10;
		end
		return res;
	endfunction

endpackage

@@ hdl/c2a_cfg.sv @@
// ----------------------------------------------------------------------------
// c2a_cfg
// APB register block: link open, stamp enable, line feed enable.
// ----------------------------------------------------------------------------
module c2a_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [c2a_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output c2a_pkg::cfg_t                 cfg
);

	logic       wr;
	logic [1:0] idx;
	c2a_pkg::cfg_t cfg_q;

	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				c2a_pkg::REG_LINK_OPEN: cfg_q.link_open        <= pwdata[0];
				c2a_pkg::REG_STAMP_EN:  cfg_q.stamp_enable     <= pwdata[0];
				c2a_pkg::REG_LINE_FEED: cfg_q.line_feed_enable <= pwdata[0];
				default: ; // unmapped: ignored
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			c2a_pkg::REG_LINK_OPEN: prdata = {31'd0, cfg_q.link_open};
			c2a_pkg::REG_STAMP_EN:  prdata = {31'd0, cfg_q.stamp_enable};
			c2a_pkg::REG_LINE_FEED: prdata = {31'd0, cfg_q.line_feed_enable};
			default:                prdata = '0;
		endcase
	end

endmodule

@@ hdl/c2a_nib_shift.sv @@
// ----------------------------------------------------------------------------
// c2a_nib_shift
// Parallel-load shift register, one hex digit out per shift, MSB first.
// ----------------------------------------------------------------------------
module c2a_nib_shift #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  c2a_pkg::shift_ctl_t  ctl,
	input  logic [W-1:0]         load_word,
	output logic [3:0]           nib
);

	logic [W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= load_word;
		end else if (ctl.shift) begin
			word_q <= {word_q[W-5:0], 4'd0};
		end
	end

	assign nib = word_q[W-1 -: 4];

endmodule

@@ hdl/c2a_seq.sv @@
// ----------------------------------------------------------------------------
// c2a_seq
// Line sequencer: walks the fields of one frame, one character per step.
// ----------------------------------------------------------------------------
module c2a_seq #(
	parameter int MAX_DATA_BYTES = c2a_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  c2a_pkg::cfg_t cfg,
	input  logic          load,
	input  logic          is_extended,
	input  logic          is_remote,
	input  logic [28:0]   frame_id,
	input  logic [3:0]    length_code,
	input  logic [63:0]   payload,
	input  logic [15:0]   time_ms,
	input  logic          step,
	output logic          busy,
	output logic          emit_valid,
	output logic [7:0]    emit_char,
	output logic          emit_last
);

	localparam int DW    = 8 * MAX_DATA_BYTES;
	localparam int CNT_W = (2 * MAX_DATA_BYTES > 8) ? $clog2(2 * MAX_DATA_BYTES) : 3;

	typedef enum logic [3:0] {
		S_IDLE, S_TYPE, S_ID, S_LEN, S_DATA, S_STAMP, S_CR, S_CR2, S_LF
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  dcnt_q;
	logic              has_data_q;
	logic [3:0]        len_q;
	logic [7:0]        type_q;

	logic              go;
	logic [3:0]        nbytes;
	logic [31:0]       id_word;
	logic [DW-1:0]     data_word;
	logic [15:0]       stamp_word;
	logic [3:0]        id_nib, data_nib, stamp_nib;
	c2a_pkg::shift_ctl_t id_ctl, data_ctl, stamp_ctl;

	assign go   = load && cfg.link_open;
	assign busy = (state_q != S_IDLE);

	// load words, top digit first
	assign id_word = is_extended ? {3'd0, frame_id} : {frame_id[11:0], 20'd0};
	assign stamp_word = (time_ms >= c2a_pkg::STAMP_MODULUS) ?
		(time_ms - c2a_pkg::STAMP_MODULUS) : time_ms;

	always_comb begin
		for (int i = 0; i < MAX_DATA_BYTES; i++) begin
			data_word[DW-1-8*i -: 8] = payload[8*i +: 8];
		end
	end

	assign nbytes = (length_code > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : length_code;

	assign id_ctl    = '{load: go, shift: step && (state_q == S_ID)};
	assign data_ctl  = '{load: go, shift: step && (state_q == S_DATA)};
	assign stamp_ctl = '{load: go, shift: step && (state_q == S_STAMP)};

	c2a_nib_shift #(.W(32)) u_id (
		.clk(clk), .ctl(id_ctl), .load_word(id_word), .nib(id_nib)
	);
	c2a_nib_shift #(.W(DW)) u_data (
		.clk(clk), .ctl(data_ctl), .load_word(data_word), .nib(data_nib)
	);
	c2a_nib_shift #(.W(16)) u_stamp (
		.clk(clk), .ctl(stamp_ctl), .load_word(stamp_word), .nib(stamp_nib)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			dcnt_q     <= '0;
			has_data_q <= 1'b0;
			len_q      <= '0;
			type_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						state_q    <= S_TYPE;
						cnt_q      <= is_extended ? CNT_W'(7) : CNT_W'(2);
						len_q      <= length_code;
						has_data_q <= (nbytes != 4'd0);
						dcnt_q     <= CNT_W'({1'b0, nbytes, 1'b0} - 6'd1);
						if (is_extended) begin
							type_q <= is_remote ? c2a_pkg::CHAR_EXT_R : c2a_pkg::CHAR_EXT_D;
						end else begin
							type_q <= is_remote ? c2a_pkg::CHAR_STD_R : c2a_pkg::CHAR_STD_D;
						end
					end
				end
				S_TYPE: if (step) begin
					state_q <= S_ID;
				end
				S_ID: if (step) begin
					if (cnt_q == '0) begin
						state_q <= S_LEN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_LEN: if (step) begin
					if (has_data_q) begin
						state_q <= S_DATA;
						cnt_q   <= dcnt_q;
					end else if (cfg.stamp_enable) begin
						state_q <= S_STAMP;
						cnt_q   <= CNT_W'(3);
					end else begin
						state_q <= S_CR;
					end
				end
				S_DATA: if (step) begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (cfg.stamp_enable) begin
						state_q <= S_STAMP;
						cnt_q   <= CNT_W'(3);
					end else begin
						state_q <= S_CR;
					end
				end
				S_STAMP: if (step) begin
					if (cnt_q == '0) begin
						state_q <= S_CR;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_CR: if (step) begin
					state_q <= cfg.line_feed_enable ? S_CR2 : S_IDLE;
				end
				S_CR2: if (step) begin
					state_q <= S_LF;
				end
				S_LF: if (step) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		emit_valid = 1'b1;
		emit_last  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				emit_valid = 1'b0;
				emit_char  = '0;
			end
			S_TYPE:  emit_char = type_q;
			S_ID:    emit_char = c2a_pkg::hex_char(id_nib);
			S_LEN:   emit_char = c2a_pkg::hex_char(len_q);
			S_DATA:  emit_char = c2a_pkg::hex_char(data_nib);
			S_STAMP: emit_char = c2a_pkg::hex_char(stamp_nib);
			S_CR: begin
				emit_char = c2a_pkg::CHAR_CR;
				emit_last = !cfg.line_feed_enable;
			end
			S_CR2:   emit_char = c2a_pkg::CHAR_CR;
			S_LF: begin
				emit_char = c2a_pkg::CHAR_LF;
				emit_last = 1'b1;
			end
			default: begin
				emit_valid = 1'b0;
				emit_char  = '0;
			end
		endcase
	end

endmodule

@@ hdl/can_frame_to_ascii_line_encoder_core.sv @@
// ----------------------------------------------------------------------------
// can_frame_to_ascii_line_encoder_core
// Turns one received CAN frame into its ASCII serial-line form, one char out.
// ----------------------------------------------------------------------------
// Flow: the first character of a frame passes through the sequencer state
//   register and then the output register; one character per cycle from the
//   digit shifters while char_ready holds. A line has N chars (N = 1 + 3|8
//   id + 1 + 2*min(dlc,MAX_DATA_BYTES) + 4*stamp + 1 + 2*lf).
// Reset: arst_n zeroes config and output regs (link closed), sequencer idle.
// ----------------------------------------------------------------------------
`include "can_frame_to_ascii_line_encoder_core_macros.svh"

module can_frame_to_ascii_line_encoder_core #(
	parameter int MAX_DATA_BYTES = c2a_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [c2a_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// frame channel
	input  logic                        frame_valid,
	output logic                        frame_ready,
	input  logic                        is_extended,
	input  logic                        is_remote,
	input  logic [28:0]                 frame_id,
	input  logic [3:0]                  length_code,
	input  logic [63:0]                 payload,
	input  logic [15:0]                 time_ms,
	// character channel
	output logic                        char_valid,
	input  logic                        char_ready,
	output logic [7:0]                  char_out,
	output logic                        last_char
);

	c2a_pkg::cfg_t cfg;
	logic          busy;
	logic          step;
	logic          ld;
	logic          emit_valid;
	logic [7:0]    emit_char;
	logic          emit_last;
	logic          char_valid_q;
	logic [7:0]    char_out_q;
	logic          last_char_q;

	c2a_cfg u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cfg(cfg)
	);

	// Frame transaction only while the sequencer is idle; a closed link
	// accepts and drops the frame without leaving idle.
	assign frame_ready = !busy;

	// The sequencer advances whenever the output register is free or
	// being emptied this cycle; the last char of a line may sit in the
	// output register while the next frame is already taken.
	assign step = !char_valid_q || char_ready;
	assign ld   = emit_valid && step;

	c2a_seq #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_seq (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.load(frame_valid && frame_ready),
		.is_extended(is_extended), .is_remote(is_remote), .frame_id(frame_id),
		.length_code(length_code), .payload(payload), .time_ms(time_ms),
		.step(step), .busy(busy),
		.emit_valid(emit_valid), .emit_char(emit_char), .emit_last(emit_last)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
			char_out_q   <= '0;
			last_char_q  <= 1'b0;
		end else if (ld) begin
			char_valid_q <= 1'b1;
			char_out_q   <= emit_char;
			last_char_q  <= emit_last;
		end else if (char_ready) begin
			char_valid_q <= 1'b0;
		end
	end

	assign char_valid = char_valid_q;
	assign char_out   = char_out_q;
	assign last_char  = last_char_q;

	// a frame taken on a closed link leaves the block idle
	`C2A_ASSERT_NEXT(a_drop_closed, clk, arst_n, frame_valid && frame_ready && !cfg.link_open, frame_ready)
	// a frame taken on an open link starts a line
	`C2A_ASSERT_NEXT(a_start_open, clk, arst_n, frame_valid && frame_ready && cfg.link_open, !frame_ready && emit_valid)
	// handing over the final character frees the sequencer
	`C2A_ASSERT_NEXT(a_last_idle, clk, arst_n, ld && emit_last, frame_ready)

endmodule
